/* hw/rtl/kwm_pkg.sv */
package kwm_pkg;

    // Heap geometry.
    localparam int MAX_WAYS = 16;
    localparam int IDX_W    = $clog2(MAX_WAYS);
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int CHD_W    = CNT_W + 1;

    // Field widths.
    localparam int FUNC_W = 3;
    localparam int VAL_W  = 32;
    localparam int WAY_W  = 4;

    // Value written into the root when its way runs dry.
    localparam logic signed [VAL_W-1:0] SENTINEL = 32'sh7FFF_FFFF;

    // One heap entry: value and the way it came from.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [WAY_W-1:0]        way;
    } t_entry;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD    = 3'd0,
        FN_BUILD   = 3'd1,
        FN_REPLACE = 3'd2,
        FN_EXHAUST = 3'd3,
        FN_CLEAR   = 3'd4
    } t_func;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLD_RD,
        ST_BLD_LAT,
        ST_SFT_RD,
        ST_SFT_CMP,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/kwm_if.sv */
// Command channel: one beat is one heap operation.
interface kwm_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [kwm_pkg::FUNC_W-1:0]               func;
    logic signed [kwm_pkg::VAL_W-1:0]         value;
    logic [kwm_pkg::WAY_W-1:0]                way;

    modport source (output valid, output func, output value, output way, input ready);
    modport sink   (input valid, input func, input value, input way, output ready);
endinterface

// Result channel: one beat per command, describing the heap afterwards.
interface kwm_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [kwm_pkg::VAL_W-1:0]         min_value;
    logic [kwm_pkg::WAY_W-1:0]                min_way;
    logic                                     valid_res;
    logic                                     done_res;
    logic                                     error;

    modport source (output valid, output min_value, output min_way, output valid_res,
                    output done_res, output error, input ready);
    modport sink   (input valid, input min_value, input min_way, input valid_res,
                    input done_res, input error, output ready);
endinterface

/* hw/rtl/kway_merge_min_heap_unit.sv */
// Channel   Dir  Beat contents
// i_in      in   func, value, way                               (valid/ready)
// o_out     out  min_value, min_way, valid_res, done_res, error (valid/ready)
//
// Load, clear and unused codes pass through the done state to the result.
// Replace and exhaust sift the new root down, one heap level at a time:
// each level is one read of both children on the two heap RAM read ports and
// one compare/write state. Build repeats that sift for every inner node, after
// a read and a latch state that fetch the node. Reset clears count, finished
// ways and the sequencer; heap RAM content is not cleared. Input ready is low while an
// operation runs; a result waiting on o_out holds the sequencer in its last state.
module kway_merge_min_heap_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kwm_in_if.sink     i_in,
    kwm_out_if.source  o_out
);
    import kwm_pkg::*;

    // Heap storage and its registered read ports.
    t_entry r_heap [MAX_WAYS];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_finished, n_finished;
    logic [IDX_W-1:0]   r_node, n_node;
    logic [IDX_W-1:0]   r_k, n_k;
    logic               r_build, n_build;
    logic               r_err, n_err;
    logic               r_out_valid, n_out_valid;

    // Datapath state.
    t_entry             r_cur, n_cur;
    t_entry             r_root;
    t_entry             r_out_min, n_out_min;
    logic               r_out_vres, n_out_vres;
    logic               r_out_done, n_out_done;
    logic               r_out_err, n_out_err;

    // Memory port controls.
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    t_entry             w_wdata;
    logic [IDX_W-1:0]   w_raddr_a;
    logic [IDX_W-1:0]   w_raddr_b;

    logic               w_in_acc;
    logic               w_full;
    logic [CHD_W-1:0]   w_lc;
    logic [CHD_W-1:0]   w_rc;
    logic               w_lc_ok;
    logic               w_rc_ok;
    logic               w_l_lt;
    logic               w_r_lt;
    t_entry             w_pick;
    t_entry             w_in_entry;

    // The command side is open only while the sequencer is idle.
    assign i_in.ready = (r_state == ST_IDLE);

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_full     = (r_count >= CNT_W'(MAX_WAYS));
    assign w_in_entry = '{value: i_in.value, way: i_in.way};

    // Child indexes of the node being sifted.
    assign w_lc    = CHD_W'({r_node, 1'b1});
    assign w_rc    = w_lc + CHD_W'(1);
    assign w_lc_ok = (w_lc < CHD_W'(r_count));
    assign w_rc_ok = (w_rc < CHD_W'(r_count));

    // Shared compare unit: left child first, then right child against the pick.
    assign w_l_lt = w_lc_ok && (r_rd_a.value < r_cur.value);
    assign w_pick = w_l_lt ? r_rd_a : r_cur;
    assign w_r_lt = w_rc_ok && (r_rd_b.value < w_pick.value);

    // Memory ports.
    always_comb begin
        w_we       = 1'b0;
        w_waddr    = r_node;
        w_wdata    = r_cur;
        w_raddr_a  = w_lc[IDX_W-1:0];
        w_raddr_b  = w_rc[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (t_func'(i_in.func) == FN_LOAD) && !w_full) begin
                    w_we    = 1'b1;
                    w_waddr = r_count[IDX_W-1:0];
                    w_wdata = w_in_entry;
                end
            end
            ST_BLD_RD: begin
                w_raddr_a = r_k;
            end
            ST_SFT_CMP: begin
                w_we    = 1'b1;
                w_waddr = r_node;
                if (w_r_lt) begin
                    w_wdata = r_rd_b;
                end else if (w_l_lt) begin
                    w_wdata = r_rd_a;
                end else begin
                    w_wdata = r_cur;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state and sequencer registers.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_finished  = r_finished;
        n_node      = r_node;
        n_k         = r_k;
        n_build     = r_build;
        n_err       = r_err;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_min   = r_out_min;
        n_out_vres  = r_out_vres;
        n_out_done  = r_out_done;
        n_out_err   = r_out_err;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_err   = 1'b0;
                    n_build = 1'b0;
                    n_state = ST_DONE;
                    case (t_func'(i_in.func))
                        FN_LOAD: begin
                            if (w_full) begin
                                n_err = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        FN_BUILD: begin
                            if (r_count != '0) begin
                                n_k     = IDX_W'((r_count - CNT_W'(1)) >> 1);
                                n_build = 1'b1;
                                n_state = ST_BLD_RD;
                            end
                        end
                        FN_REPLACE, FN_EXHAUST: begin
                            if (r_count == '0) begin
                                n_err = 1'b1;
                            end else begin
                                n_node    = '0;
                                n_cur.way = r_root.way;
                                if (t_func'(i_in.func) == FN_REPLACE) begin
                                    n_cur.value = i_in.value;
                                end else begin
                                    n_cur.value = SENTINEL;
                                    if (r_finished < r_count) begin
                                        n_finished = r_finished + CNT_W'(1);
                                    end
                                end
                                n_state = ST_SFT_RD;
                            end
                        end
                        FN_CLEAR: begin
                            n_count    = '0;
                            n_finished = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BLD_RD: begin
                n_state = ST_BLD_LAT;
            end
            ST_BLD_LAT: begin
                n_cur   = r_rd_a;
                n_node  = r_k;
                n_state = ST_SFT_RD;
            end
            ST_SFT_RD: begin
                n_state = ST_SFT_CMP;
            end
            ST_SFT_CMP: begin
                if (w_r_lt) begin
                    n_node  = w_rc[IDX_W-1:0];
                    n_state = ST_SFT_RD;
                end else if (w_l_lt) begin
                    n_node  = w_lc[IDX_W-1:0];
                    n_state = ST_SFT_RD;
                end else if (r_build && (r_k != '0)) begin
                    n_k     = r_k - IDX_W'(1);
                    n_state = ST_BLD_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Post the result once the output register is free.
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_vres  = (r_count != '0);
                    n_out_done  = (r_count != '0) && (r_finished == r_count);
                    n_out_err   = r_err;
                    n_out_min   = (r_count != '0) ? r_root : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_finished  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_node     <= n_node;
        r_k        <= n_k;
        r_build    <= n_build;
        r_err      <= n_err;
        r_cur      <= n_cur;
        r_out_min  <= n_out_min;
        r_out_vres <= n_out_vres;
        r_out_done <= n_out_done;
        r_out_err  <= n_out_err;
    end

    // Heap RAM with a shadow copy of the root entry.
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_heap[w_raddr_a];
        r_rd_b <= r_heap[w_raddr_b];
        if (w_we) begin
            r_heap[w_waddr] <= w_wdata;
        end
        if (w_we && (w_waddr == '0)) begin
            r_root <= w_wdata;
        end
    end

    // Result channel.
    assign o_out.valid     = r_out_valid;
    assign o_out.min_value = r_out_min.value;
    assign o_out.min_way   = r_out_min.way;
    assign o_out.valid_res = r_out_vres;
    assign o_out.done_res  = r_out_done;
    assign o_out.error     = r_out_err;

    // The heap never holds more entries than it has slots.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WAYS))
        else $error("heap count beyond capacity");

    // Finished ways never outnumber the entries.
    a_fin_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished <= r_count)
        else $error("finished ways exceed heap count");

    // A sift only ever visits nodes inside the heap.
    a_node_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SFT_RD || r_state == ST_SFT_CMP) |-> (CNT_W'(r_node) < r_count))
        else $error("sift node outside heap");

    // A finished merge implies a non-empty heap in the result.
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.done_res) |-> o_out.valid_res)
        else $error("done flagged on empty heap");

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kwm_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_CMDS   = 900;
    localparam int QUIET_TAIL  = 120;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_LEN   = 40;

    // One command beat as the sender sees it; func is kept raw so spare codes fit.
    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  value;
        logic [WAY_W-1:0]  way;
    } t_cmd;

    // What the block reports about the heap root after one command.
    typedef struct {
        logic signed [VAL_W-1:0] min_value;
        logic [WAY_W-1:0]        min_way;
        logic                    valid_res;
        logic                    done_res;
        logic                    error;
    } t_root_report;

    logic i_clk;
    logic i_rst_n;

    kwm_in_if  cmd_if ();
    kwm_out_if root_if ();

    kway_merge_min_heap_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (root_if)
    );

    // Shadow heap kept in step with every accepted command.
    t_entry heap_mem [MAX_WAYS];
    int     heap_n;
    int     finished_n;

    t_cmd         cmd_queue [$];
    t_root_report root_reports [$];

    int cmd_total;
    int cmds_taken;
    int roots_seen;
    int mismatches;
    int cycle_cnt;
    int send_gap;
    int recv_gap;
    int hold_left;
    bit hold_done;

    // Sift one node down: left child if strictly smaller, then right if smaller still.
    function automatic void sift_from(int start);
        int     node;
        int     lc;
        int     rc;
        int     pick;
        t_entry tmp;
        node = start;
        while (node < heap_n) begin
            lc   = 2 * node + 1;
            rc   = 2 * node + 2;
            pick = node;
            if (lc < heap_n && $signed(heap_mem[lc].value) < $signed(heap_mem[node].value))
                pick = lc;
            if (rc < heap_n && $signed(heap_mem[rc].value) < $signed(heap_mem[pick].value))
                pick = rc;
            if (pick == node)
                break;
            tmp            = heap_mem[node];
            heap_mem[node] = heap_mem[pick];
            heap_mem[pick] = tmp;
            node           = pick;
        end
    endfunction

    // Apply one command to the shadow heap and return the root it leaves behind.
    function automatic t_root_report heap_step(t_cmd c);
        t_root_report r;
        logic         refused;
        refused = 1'b0;
        case (c.func)
            FN_LOAD: begin
                if (heap_n >= MAX_WAYS) begin
                    refused = 1'b1;
                end else begin
                    heap_mem[heap_n].value = c.value;
                    heap_mem[heap_n].way   = c.way;
                    heap_n++;
                end
            end
            FN_BUILD: begin
                for (int k = (heap_n - 1) / 2; heap_n > 0 && k >= 0; k--)
                    sift_from(k);
            end
            FN_REPLACE, FN_EXHAUST: begin
                if (heap_n == 0) begin
                    refused = 1'b1;
                end else begin
                    if (c.func == FN_REPLACE) begin
                        heap_mem[0].value = c.value;
                    end else begin
                        heap_mem[0].value = SENTINEL;
                        if (finished_n < heap_n)
                            finished_n++;
                    end
                    sift_from(0);
                end
            end
            FN_CLEAR: begin
                heap_n     = 0;
                finished_n = 0;
            end
            default: ;
        endcase
        if (heap_n > 0) begin
            r.min_value = heap_mem[0].value;
            r.min_way   = heap_mem[0].way;
            r.valid_res = 1'b1;
            r.done_res  = (finished_n == heap_n);
        end else begin
            r.min_value = '0;
            r.min_way   = '0;
            r.valid_res = 1'b0;
            r.done_res  = 1'b0;
        end
        r.error = refused;
        return r;
    endfunction

    function automatic void push_cmd(logic [FUNC_W-1:0] f, logic [VAL_W-1:0] v,
                                     logic [WAY_W-1:0] w);
        t_cmd c;
        c.func  = f;
        c.value = v;
        c.way   = w;
        cmd_queue.push_back(c);
    endfunction

    // Values lean toward extremes and a narrow band so that ties show up often.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return SENTINEL;
            1:       return {1'b1, {(VAL_W-1){1'b0}}};
            2, 3:    return $urandom_range(0, 16) - 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [WAY_W-1:0] pick_way();
        return WAY_W'($urandom_range(0, MAX_WAYS - 1));
    endfunction

    function automatic void check_field(string name, logic [VAL_W-1:0] exp_v,
                                        logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Command source: holds a beat until taken, with random gaps early on.
    always @(posedge i_clk) begin : cmd_drive
        logic take;
        bit   quiet;
        take  = cmd_if.valid && cmd_if.ready;
        quiet = (cmds_taken + QUIET_TAIL >= cmd_total);
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap     <= 0;
        end else begin
            if (take) begin
                root_reports.push_back(heap_step(cmd_queue.pop_front()));
                cmds_taken <= cmds_taken + 1;
            end
            if (cmd_if.valid && !take) begin
                // Keep offering the same beat.
            end else if (send_gap > 0) begin
                send_gap     <= send_gap - 1;
                cmd_if.valid <= 1'b0;
            end else if (cmd_queue.size() == 0) begin
                cmd_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                send_gap     <= $urandom_range(1, 16) - 1;
                cmd_if.valid <= 1'b0;
            end else begin
                cmd_if.valid <= 1'b1;
                cmd_if.func  <= cmd_queue[0].func;
                cmd_if.value <= cmd_queue[0].value;
                cmd_if.way   <= cmd_queue[0].way;
            end
        end
    end

    // One long hold on the result side so the block backs up into its input.
    always @(posedge i_clk) begin : long_hold
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && roots_seen == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result sink ready, with random stall bursts early on.
    always @(posedge i_clk) begin : root_ready
        bit quiet;
        quiet = (cmds_taken + QUIET_TAIL >= cmd_total);
        if (!i_rst_n) begin
            root_if.ready <= 1'b0;
            recv_gap      <= 0;
        end else if (hold_left > 0 || (!hold_done && roots_seen == HOLD_AT)) begin
            root_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap      <= recv_gap - 1;
            root_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap      <= $urandom_range(1, 16) - 1;
            root_if.ready <= 1'b0;
        end else begin
            root_if.ready <= 1'b1;
        end
    end

    // Result monitor: every beat is checked against the oldest predicted root.
    always @(posedge i_clk) begin : root_check
        t_root_report exp_r;
        if (i_rst_n && root_if.valid && root_if.ready) begin
            roots_seen <= roots_seen + 1;
            if (root_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, actual value %0h way %0h",
                         $time, root_if.min_value, root_if.min_way);
            end else begin
                exp_r = root_reports.pop_front();
                check_field("min_value", exp_r.min_value, root_if.min_value);
                check_field("min_way", VAL_W'(exp_r.min_way), VAL_W'(root_if.min_way));
                check_field("valid_res", VAL_W'(exp_r.valid_res), VAL_W'(root_if.valid_res));
                check_field("done_res", VAL_W'(exp_r.done_res), VAL_W'(root_if.done_res));
                check_field("error", VAL_W'(exp_r.error), VAL_W'(root_if.error));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int k;
        int ops;
        i_rst_n       = 1'b0;
        cmd_if.valid  = 1'b0;
        cmd_if.func   = '0;
        cmd_if.value  = '0;
        cmd_if.way    = '0;
        root_if.ready = 1'b0;
        heap_n        = 0;
        finished_n    = 0;
        cmds_taken    = 0;
        roots_seen    = 0;
        mismatches    = 0;
        cycle_cnt     = 0;
        cmd_total     = 1 << 30;

        // Directed: empty-heap errors, spare codes, then a small merge run.
        push_cmd(FN_REPLACE, 32'd123, '0);
        push_cmd(FN_EXHAUST, '0, '0);
        push_cmd(FN_BUILD, '0, '0);
        for (int f = FN_CLEAR + 1; f < (1 << FUNC_W); f++)
            push_cmd(FUNC_W'(f), $urandom(), pick_way());
        push_cmd(FN_CLEAR, '0, '0);
        push_cmd(FN_LOAD, SENTINEL, 4'd0);
        push_cmd(FN_LOAD, {1'b1, {(VAL_W-1){1'b0}}}, 4'd15);
        push_cmd(FN_LOAD, '1, 4'd10);
        push_cmd(FN_LOAD, '0, 4'd5);
        push_cmd(FN_BUILD, '0, '0);
        push_cmd(FN_REPLACE, {1'b1, {(VAL_W-1){1'b0}}}, '0);
        push_cmd(FN_REPLACE, SENTINEL, '0);
        // A load after build lands unsorted until the next build.
        push_cmd(FN_LOAD, 32'sd7, 4'd3);
        // Exhaust past the point where every way is finished.
        repeat (6) push_cmd(FN_EXHAUST, '0, '0);
        push_cmd(FN_CLEAR, '0, '0);

        // Random: mostly well-formed merge runs, some noise.
        while (cmd_queue.size() < RAND_CMDS + 22) begin
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 4) != 0)
                    push_cmd(FN_CLEAR, $urandom(), pick_way());
                k = ($urandom_range(0, 3) == 0) ? MAX_WAYS : $urandom_range(1, MAX_WAYS);
                repeat (k) push_cmd(FN_LOAD, pick_value(), pick_way());
                if (k == MAX_WAYS && $urandom_range(0, 1) == 0)
                    push_cmd(FN_LOAD, pick_value(), pick_way());
                push_cmd(FN_BUILD, $urandom(), pick_way());
                ops = $urandom_range(k, 3 * k + 4);
                repeat (ops) begin
                    case ($urandom_range(0, 19))
                        0:                push_cmd(FN_LOAD, pick_value(), pick_way());
                        1:                push_cmd(FN_BUILD, $urandom(), pick_way());
                        2, 3, 4, 5,
                        6, 7, 8:          push_cmd(FN_EXHAUST, $urandom(), pick_way());
                        default:          push_cmd(FN_REPLACE, pick_value(), pick_way());
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    push_cmd(FUNC_W'($urandom_range(0, (1 << FUNC_W) - 1)), $urandom(),
                             pick_way());
            end
        end
        cmd_total = cmd_queue.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || root_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_if.sv
hw/rtl/kway_merge_min_heap_unit.sv
test/tb_top.sv
